// ----- hdl/gbn_pkg.sv -----
// Package for the Go-Back-N sender window: event, packet and status codes,
// configuration register indexes and the command/status structs.
// No dependencies.
`default_nettype none
package gbn_pkg;

	localparam int SEQ_BITS = 16;
	localparam int ST_W = SEQ_BITS + 1;
	localparam int DIFF_W = SEQ_BITS + 2;
	localparam int MAX_WINDOW_DEF = 16;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W = 24;
	localparam int OUT_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SEGMENT_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TRIES = 2'd2;

	localparam logic [15:0] SEGMENT_COUNT_RST = 16'd1;
	localparam logic [4:0] WINDOW_SIZE_RST = 5'd4;
	localparam logic [7:0] MAX_TRIES_RST = 8'd10;

	localparam logic [1:0] FUNC_START = 2'd0;
	localparam logic [1:0] FUNC_ACK = 2'd1;
	localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_TERM = 2'd1;
	localparam logic [1:0] KIND_NONE = 2'd2;

	localparam logic [1:0] STAT_SENDING = 2'd0;
	localparam logic [1:0] STAT_WAITING = 2'd1;
	localparam logic [1:0] STAT_DONE = 2'd2;
	localparam logic [1:0] STAT_GAVE_UP = 2'd3;

	typedef struct packed {
		logic load;       // apply the accepted event to the window state
		logic emit_pkt;   // send the next sequence number
		logic emit_wait;  // send the waiting status word
		logic emit_end;   // send the finished or gave-up status word
	} gbn_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic active;
		logic term;
		logic retry_ge_max;
		logic can_send;
		logic out_free;
	} gbn_sts_t;

endpackage
`default_nettype wire

// ----- hdl/go_back_n_sender_window_core.sv -----
// Go-Back-N sender window, top level. An accepted event that applies emits up to
// MAX_WINDOW packet words, one per cycle while the output is not stalled, and then
// a status word; a terminal ack or a give-up emits the status word alone, and an
// event that does not apply emits nothing. The controller handles one event at a
// time; the output register lets the next event in while the status word waits.
// Reset is asynchronous and resets the configuration, window state and output valid.
`default_nettype none
module go_back_n_sender_window_core
	import gbn_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // ack_number[15:0], ack_is_terminal[16]
	input  wire logic [1:0]            s_tuser,   // func[1:0]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,   // seq_number[15:0], packet_kind[17:16], status[19:18]
	output logic                       m_tlast    // last
);

	gbn_cmd_t cmd;
	gbn_sts_t sts;

	gbn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gbn_dpath #(
		.MAX_WINDOW (MAX_WINDOW)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule
`default_nettype wire

// ----- hdl/gbn_ctrl.sv -----
// Controller of the Go-Back-N sender window: takes events and sequences
// the packet and status words. Depends on gbn_pkg.
`default_nettype none
module gbn_ctrl
	import gbn_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire gbn_sts_t sts,
	output gbn_cmd_t      cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_FILL = 2'd1;
	localparam logic [1:0] ST_FINISH = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (sts.func == FUNC_START) begin
						state_d = ST_FILL;
					end else if (sts.func == FUNC_ACK && sts.active) begin
						state_d = sts.term ? ST_FINISH : ST_FILL;
					end else if (sts.func == FUNC_TIMEOUT && sts.active) begin
						state_d = sts.retry_ge_max ? ST_FINISH : ST_FILL;
					end
				end
			end
			ST_FILL: begin
				if (sts.out_free) begin
					if (sts.can_send) begin
						cmd.emit_pkt = 1'b1;
					end else begin
						cmd.emit_wait = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit_end = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gbn_dpath.sv -----
// Datapath of the Go-Back-N sender window: configuration registers, window
// state, window check and the output word register. Depends on gbn_pkg.
`default_nettype none
module gbn_dpath
	import gbn_pkg::*;
#(
	parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	input  wire logic [1:0]            s_tuser,
	input  wire gbn_cmd_t              cmd,
	output gbn_sts_t                   sts,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata,
	output logic                       m_tlast
);

	localparam int WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int CW = (WIN_W > 5) ? WIN_W : 5;

	logic [15:0] seg_count_q;
	logic [4:0] win_size_q;
	logic [7:0] max_tries_q;

	logic [ST_W-1:0] base_q;
	logic [ST_W-1:0] next_q;
	logic [7:0] retry_q;
	logic active_q;
	logic [WIN_W-1:0] sent_q;
	logic [1:0] end_code_q;

	logic m_tvalid_q;
	logic [15:0] seq_q;
	logic [1:0] kind_q;
	logic [1:0] stat_q;
	logic last_q;

	logic [15:0] ack_num;
	logic ack_term;
	logic [CW-1:0] ws_ext;
	logic [WIN_W-1:0] win;
	logic signed [DIFF_W-1:0] diff;
	logic ack_above;

	assign ack_num = s_tdata[15:0];
	assign ack_term = s_tdata[16];

	// Window size zero counts as one; sizes above the maximum saturate.
	always_comb begin
		ws_ext = CW'(win_size_q);
		if (ws_ext == '0) begin
			win = WIN_W'(1);
		end else if (ws_ext > CW'(MAX_WINDOW)) begin
			win = WIN_W'(MAX_WINDOW);
		end else begin
			win = WIN_W'(ws_ext);
		end
	end

	// The base is signed (it starts at minus one); next_seq is not.
	assign diff = $signed({1'b0, next_q}) - $signed({base_q[ST_W-1], base_q});
	assign ack_above = $signed({2'b00, ack_num}) > $signed({base_q[ST_W-1], base_q});

	assign sts.func = s_tuser;
	assign sts.active = active_q;
	assign sts.term = ack_term;
	assign sts.retry_ge_max = (retry_q >= max_tries_q);
	assign sts.can_send = (sent_q < win) && (next_q <= {1'b0, seg_count_q})
		&& !(diff > $signed(DIFF_W'(win)));
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_count_q <= SEGMENT_COUNT_RST;
			win_size_q <= WINDOW_SIZE_RST;
			max_tries_q <= MAX_TRIES_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SEGMENT_COUNT: seg_count_q <= cfg_data;
				REG_WINDOW_SIZE: win_size_q <= cfg_data[4:0];
				REG_MAX_TRIES: max_tries_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '1;
			next_q <= '0;
			retry_q <= '0;
			active_q <= 1'b0;
			sent_q <= '0;
		end else if (cmd.load) begin
			sent_q <= '0;
			if (s_tuser == FUNC_START) begin
				base_q <= '1;
				next_q <= '0;
				retry_q <= '0;
				active_q <= 1'b1;
			end else if (s_tuser == FUNC_ACK && active_q) begin
				retry_q <= '0;
				if (ack_term) begin
					active_q <= 1'b0;
				end else if (ack_above) begin
					base_q <= {1'b0, ack_num};
				end
			end else if (s_tuser == FUNC_TIMEOUT && active_q) begin
				next_q <= base_q + ST_W'(1);
				if (retry_q >= max_tries_q) begin
					active_q <= 1'b0;
				end else begin
					retry_q <= retry_q + 8'd1;
				end
			end
		end else if (cmd.emit_pkt) begin
			next_q <= next_q + ST_W'(1);
			sent_q <= sent_q + WIN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			end_code_q <= (s_tuser == FUNC_ACK) ? STAT_DONE : STAT_GAVE_UP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit_pkt || cmd.emit_wait || cmd.emit_end) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_pkt) begin
			seq_q <= next_q[15:0];
			kind_q <= (next_q == {1'b0, seg_count_q}) ? KIND_TERM : KIND_DATA;
			stat_q <= STAT_SENDING;
			last_q <= 1'b0;
		end else if (cmd.emit_wait || cmd.emit_end) begin
			seq_q <= '0;
			kind_q <= KIND_NONE;
			stat_q <= cmd.emit_wait ? STAT_WAITING : end_code_q;
			last_q <= 1'b1;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {4'd0, stat_q, kind_q, seq_q};
	assign m_tlast = last_q;

endmodule
`default_nettype wire

// ----- hdl/gbn_chk.sv -----
// Port-level checker for the Go-Back-N sender window and its bind to the top level.
// Depends on gbn_pkg.
`default_nettype none
module gbn_chk
	import gbn_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_tvalid,
	input wire logic                  s_tready,
	input wire logic                  m_tvalid,
	input wire logic                  m_tready,
	input wire logic [OUT_DATA_W-1:0] m_tdata,
	input wire logic                  m_tlast
);

	// A stalled output word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output word changed while stalled");

	// A status word carries no packet and sequence number zero.
	a_status_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[17:16] == KIND_NONE && m_tdata[15:0] == 16'd0
			&& m_tdata[19:18] != STAT_SENDING)
		else $error("malformed status word");

	// A packet word is always data or terminal and reports sending.
	a_packet_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[19:18] == STAT_SENDING
			&& (m_tdata[17:16] == KIND_DATA || m_tdata[17:16] == KIND_TERM))
		else $error("malformed packet word");

	// Only a status word ends an event, so no event is taken between packet words.
	a_no_accept_mid_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !(s_tvalid && s_tready))
		else $error("event accepted while packets of the previous one are pending");

endmodule

bind go_back_n_sender_window_core gbn_chk u_gbn_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
`default_nettype wire

// ----- tb/go_back_n_sender_window_core_tb.sv -----
// Testbench for go_back_n_sender_window_core: drives start, ack and timeout events with
// random gaps and output stalls, and checks every packet and status word against a window
// tracker kept in the testbench. Depends on gbn_pkg and the core RTL only.
`default_nettype none
module go_back_n_sender_window_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gbn_pkg::*;

	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [15:0] seq;
		logic [1:0]  kind;
		logic [1:0]  stat;
		logic        last;
	} tx_word_t;

	// Tracks the sender window and holds the words the core still owes.
	class window_tracker;
		logic [15:0] seg_count;
		logic [4:0]  win_size;
		logic [7:0]  tries_max;
		logic [16:0] base;
		logic [16:0] nxt;
		logic [7:0]  retries;
		logic        running;
		tx_word_t    due_words[$];
		int          fails;

		function new();
			seg_count = SEGMENT_COUNT_RST;
			win_size = WINDOW_SIZE_RST;
			tries_max = MAX_TRIES_RST;
			base = '1;
			nxt = '0;
			retries = '0;
			running = 1'b0;
			fails = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				REG_SEGMENT_COUNT: seg_count = val;
				REG_WINDOW_SIZE: win_size = val[4:0];
				REG_MAX_TRIES: tries_max = val[7:0];
				default: ;
			endcase
		endfunction

		function int base_val();
			return int'($signed(base));
		endfunction

		function void push(logic [15:0] seq, logic [1:0] kind, logic [1:0] stat, logic last);
			tx_word_t w;
			w.seq = seq;
			w.kind = kind;
			w.stat = stat;
			w.last = last;
			due_words.push_back(w);
		endfunction

		// Sends what fits in the window, then the waiting status word.
		function void send_window();
			int win;
			int n;
			int nx;
			win = int'(win_size);
			if (win < 1) win = 1;
			if (win > MAX_WINDOW_DEF) win = MAX_WINDOW_DEF;
			n = 0;
			while (n < win) begin
				nx = int'(nxt);
				if (nx > int'(seg_count) || nx - base_val() > win) break;
				push(nx[15:0], (nx == int'(seg_count)) ? KIND_TERM : KIND_DATA, STAT_SENDING, 1'b0);
				n++;
				nxt = 17'(nx + 1);
			end
			push(16'd0, KIND_NONE, STAT_WAITING, 1'b1);
		endfunction

		// Applies one accepted event and returns how many words it owes.
		function int take_event(logic [1:0] func, logic [15:0] ack, logic term);
			int before_cnt;
			before_cnt = due_words.size();
			if (func == FUNC_START) begin
				base = '1;
				nxt = '0;
				retries = '0;
				running = 1'b1;
				send_window();
			end else if (func == FUNC_ACK && running) begin
				retries = '0;
				if (term) begin
					running = 1'b0;
					push(16'd0, KIND_NONE, STAT_DONE, 1'b1);
				end else begin
					if (int'(ack) > base_val()) base = {1'b0, ack};
					send_window();
				end
			end else if (func == FUNC_TIMEOUT && running) begin
				nxt = 17'(base_val() + 1);
				if (retries >= tries_max) begin
					running = 1'b0;
					push(16'd0, KIND_NONE, STAT_GAVE_UP, 1'b1);
				end else begin
					retries = retries + 8'd1;
					send_window();
				end
			end
			return due_words.size() - before_cnt;
		endfunction

		function void check_word(logic [15:0] seq, logic [1:0] kind, logic [1:0] stat,
				logic last);
			tx_word_t w;
			if (due_words.size() == 0) begin
				$error("unexpected word: seq_number %0d packet_kind %0d status %0d last %0d",
					seq, kind, stat, last);
				fails++;
				return;
			end
			w = due_words.pop_front();
			if (seq !== w.seq) begin
				$error("seq_number: expected %0d, got %0d", w.seq, seq);
				fails++;
			end
			if (kind !== w.kind) begin
				$error("packet_kind: expected %0d, got %0d", w.kind, kind);
				fails++;
			end
			if (stat !== w.stat) begin
				$error("status: expected %0d, got %0d", w.stat, stat);
				fails++;
			end
			if (last !== w.last) begin
				$error("last: expected %0d, got %0d", w.last, last);
				fails++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata;   // ack_number[15:0], ack_is_terminal[16]
	logic [1:0]            s_tuser;   // func[1:0]
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;   // seq_number[15:0], packet_kind[17:16], status[19:18]
	logic                  m_tlast;   // last

	window_tracker wt = new();
	int issued = 0;
	logic steady = 1'b0;

	go_back_n_sender_window_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("go_back_n_sender_window_core_tb: done, errors");
		$finish;
	end

	// Output side: random stalls between words, checked on every accepted word.
	initial begin
		int n;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		m_tready <= 1'b1;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				wt.check_word(m_tdata[15:0], m_tdata[17:16], m_tdata[19:18], m_tlast);
				n = steady ? 0 : $urandom_range(0, 11);
				if (n > 0) begin
					m_tready <= 1'b0;
					repeat (n) @(posedge clk);
					m_tready <= 1'b1;
				end
			end
		end
	end

	// Called at a clock edge; leaves s_tvalid high after the handshake edge.
	task automatic send_event(input logic [1:0] func, input logic [15:0] ack, input logic term);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, term, ack};
		s_tuser <= func;
		do @(posedge clk); while (!s_tready);
		if (wt.take_event(func, ack, term) > 0) issued++;
	endtask

	// Stops input and waits until the core has drained every owed word.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (wt.due_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		wt.set_reg(idx, val);
	endtask

	task automatic set_regs(input logic [15:0] seg, input logic [4:0] win, input logic [7:0] tries);
		write_reg(REG_SEGMENT_COUNT, seg);
		write_reg(REG_WINDOW_SIZE, 16'(win));
		write_reg(REG_MAX_TRIES, 16'(tries));
		cfg_wen <= 1'b0;
	endtask

	// Mostly well-formed transfers: acks inside the flight range, timeouts, a terminal
	// ack once the terminal packet is out; some stale, far-off and stray events.
	task automatic random_event();
		int pick;
		int lo;
		int hi;
		logic [15:0] any_ack;
		logic any_term;
		pick = $urandom_range(0, 99);
		any_ack = 16'($urandom);
		any_term = 1'($urandom);
		lo = wt.base_val() + 1;
		hi = int'(wt.nxt) - 1;
		if (!wt.running) begin
			if (pick < 75) send_event(FUNC_START, any_ack, any_term);
			else if (pick < 85) send_event(FUNC_ACK, any_ack, any_term);
			else if (pick < 95) send_event(FUNC_TIMEOUT, any_ack, any_term);
			else send_event(FUNC_UNUSED, any_ack, any_term);
		end else if (int'(wt.nxt) > int'(wt.seg_count) && pick < 30) begin
			send_event(FUNC_ACK, any_ack, 1'b1);
		end else if (pick < 60 && hi >= lo) begin
			send_event(FUNC_ACK, 16'($urandom_range(lo, hi)), 1'b0);
		end else if (pick < 70) begin
			send_event(FUNC_ACK, 16'($urandom_range(0, (lo > 0) ? lo - 1 : 0)), 1'b0);
		end else if (pick < 84) begin
			send_event(FUNC_TIMEOUT, any_ack, any_term);
		end else if (pick < 90) begin
			send_event(FUNC_ACK, any_ack, 1'b0);
		end else if (pick < 93) begin
			send_event(FUNC_ACK, any_ack, 1'b1);
		end else if (pick < 96) begin
			send_event(FUNC_START, any_ack, any_term);
		end else begin
			send_event(FUNC_UNUSED, any_ack, any_term);
		end
	endtask

	initial begin
		int sel;
		int target;
		logic [15:0] seg;
		logic [4:0] win;
		logic [7:0] tries;
		arst_n <= 1'b0;
		cfg_wen <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: events while idle, a two-packet transfer, terminal ack.
		send_event(FUNC_ACK, 16'hFFFF, 1'b1);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		send_event(FUNC_UNUSED, 16'hA5A5, 1'b1);
		send_event(FUNC_START, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'h0001, 1'b1);
		settle();

		// Full window, stale acks, an ack far beyond next_seq, retries running out.
		set_regs(16'd20, 5'd16, 8'd2);
		send_event(FUNC_START, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'd3, 1'b0);
		send_event(FUNC_ACK, 16'd1, 1'b0);
		send_event(FUNC_ACK, 16'd0, 1'b0);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'hFFFF, 1'b0);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		send_event(FUNC_START, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'd7, 1'b0);
		send_event(FUNC_START, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'd0, 1'b1);
		settle();

		// Terminal packet at zero, window of zero, giving up on the first timeout.
		set_regs(16'd0, 5'd0, 8'd0);
		send_event(FUNC_START, 16'h0000, 1'b0);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		settle();

		// Largest values: the window saturates and sequence numbers reach the top.
		set_regs(16'hFFFF, 5'd31, 8'd255);
		send_event(FUNC_START, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'hFFFE, 1'b0);
		send_event(FUNC_TIMEOUT, 16'h0000, 1'b0);
		send_event(FUNC_ACK, 16'h0000, 1'b1);
		settle();

		repeat (8) begin
			sel = $urandom_range(0, 9);
			seg = (sel == 0) ? 16'd0 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(1, 40));
			sel = $urandom_range(0, 9);
			win = (sel == 0) ? 5'd0 : (sel == 1) ? 5'd31 : (sel == 2) ? 5'd16 : 5'($urandom);
			sel = $urandom_range(0, 9);
			tries = (sel == 0) ? 8'd0 : (sel == 1) ? 8'd255 : 8'($urandom_range(1, 4));
			set_regs(seg, win, tries);
			steady = ($urandom_range(0, 3) == 0);
			target = issued + 31;
			while (issued < target) random_event();
			settle();
			steady = 1'b0;
		end

		if (wt.fails == 0) begin
			$display("go_back_n_sender_window_core_tb: done, clean");
		end else begin
			$display("go_back_n_sender_window_core_tb: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/gbn_pkg.sv
hdl/gbn_ctrl.sv
hdl/gbn_dpath.sv
hdl/go_back_n_sender_window_core.sv
hdl/gbn_chk.sv
tb/go_back_n_sender_window_core_tb.sv
